@@ rtl/mvc_pkg.sv @@
// Shared types, constants and tables of the multi-voice chorus delay core.
// Holds the sine quarter-wave table, the voice phase spacing table and the
// command and status structs between controller and datapath. No dependencies.
package mvc_pkg;

  localparam int SINE_TABLE_SIZE = 256;
  localparam int SIDX_W = $clog2(4 * SINE_TABLE_SIZE);
  localparam int SKW = $clog2(SINE_TABLE_SIZE + 1);
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_W = 24;
  localparam int WET_W = 18;
  localparam logic [14:0] FB_LIMIT = 15'd31130;
  localparam logic [16:0] Q15_ONE = 17'd32768;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VOICE_COUNT    = 4'd0,
    REG_LFO_SHAPE      = 4'd1,
    REG_BASE_DELAY     = 4'd2,
    REG_DEPTH          = 4'd3,
    REG_LFO_PHASE_STEP = 4'd4,
    REG_FEEDBACK_GAIN  = 4'd5,
    REG_WET_MIX        = 4'd6,
    REG_STEREO_SPREAD  = 4'd7
  } cfg_reg_t;

  typedef logic [15:0] sine_tab_t [0:SINE_TABLE_SIZE];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] e;
    int k;
    for (k = 0; k <= SINE_TABLE_SIZE; k++) begin
      x = (64'(k) * HALF_PI_Q30) / SINE_TABLE_SIZE;
      x2 = (x * x) >> 30;
      t = ONE_Q30;
      t = ONE_Q30 - ((x2 * t) >> 30) / 110;
      t = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s = (x * t) >> 30;
      e = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tab[k] = 16'(e);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // Quotient and remainder of 2^24 divided by the voice count.
  localparam logic [23:0] OFF_Q [0:16] = '{
    24'd0, 24'd0, 24'd8388608, 24'd5592405, 24'd4194304, 24'd3355443,
    24'd2796202, 24'd2396745, 24'd2097152, 24'd1864135, 24'd1677721,
    24'd1525201, 24'd1398101, 24'd1290555, 24'd1198372, 24'd1118481,
    24'd1048576
  };
  localparam logic [4:0] OFF_R [0:16] = '{
    5'd0, 5'd0, 5'd0, 5'd1, 5'd0, 5'd1, 5'd4, 5'd1, 5'd0, 5'd1, 5'd6,
    5'd5, 5'd4, 5'd1, 5'd8, 5'd1, 5'd0
  };

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic lfo;
    logic mul;
    logic dly;
    logic adr;
    logic rd1;
    logic intp;
    logic echo;
    logic fb;
    logic wr;
    logic div_a;
    logic div_b;
    logic cap_a;
    logic cap_b;
    logic mix;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic last_voice;
    logic stereo;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -40'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/multi_voice_chorus_delay_core.sv @@
// Multi-voice chorus delay core: one frame in, one frame out per transaction.
// The per-voice steps of the n active voices share the single delay RAM read port;
// the one-bit-per-cycle wet divider runs once for mono and twice for stereo
// frames; one frame is in work at a time.
// Reset: synchronous; afterwards all MAX_VOICES*DELAY_DEPTH words of the delay RAM
// are cleared with in_stall high. Uses mvc_pkg, mvc_ctrl and mvc_datapath.
module multi_voice_chorus_delay_core #(
  parameter int MAX_VOICES = 8,
  parameter int DELAY_DEPTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mvc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic signed [15:0]             left_sample,
  input  logic signed [15:0]             right_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [15:0]             left_out,
  output logic signed [15:0]             right_out
);

  mvc_pkg::dp_cmd_t    cmd;
  mvc_pkg::dp_status_t status;

  mvc_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status(status),
    .cmd(cmd)
  );

  mvc_datapath #(
    .MAX_VOICES(MAX_VOICES),
    .DELAY_DEPTH(DELAY_DEPTH)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_type(req_type),
    .left_sample(left_sample),
    .right_sample(right_sample),
    .left_out(left_out),
    .right_out(right_out),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd(cmd),
    .status(status)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("Pending result overwritten.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Input taken again before the frame finished.");

  a_single_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_wr, cmd.load, cmd.lfo, cmd.wr, cmd.mix, cmd.out_load}))
    else $error("Conflicting datapath commands.");

endmodule

@@ rtl/mvc_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the delay lines. No dependencies.
module mvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mvc_div.sv @@
// Restoring divider, one quotient bit per cycle, giving the floor of a signed
// dividend over a small positive divisor. Uses nothing from the package.
module mvc_div #(
  parameter int DW = 24,
  parameter int NW = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic [NW-1:0]        divisor,
  output logic signed [DW-1:0] quotient,
  output logic                 done
);

  localparam int CW = $clog2(DW);

  logic                    busy;
  logic [CW-1:0]           cnt;
  logic                    neg;
  logic [DW-1:0]           acc;
  logic [NW-1:0]           rem;
  logic [NW:0]             rem_sh;
  logic                    ge;

  assign rem_sh = {rem, acc[DW-1]};
  assign ge = rem_sh >= {1'b0, divisor};
  assign quotient = neg ? $signed(~acc) : $signed(acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
        neg <= dividend[DW-1];
        acc <= dividend[DW-1] ? ~dividend : dividend;
        rem <= '0;
      end else if (busy) begin
        acc <= {acc[DW-2:0], ge};
        rem <= ge ? NW'(rem_sh - {1'b0, divisor}) : NW'(rem_sh);
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/mvc_ctrl.sv @@
// Controller state machine of the chorus core: sequences the clearing pass,
// the per-voice steps, the wet division and the output mix. Uses mvc_pkg.
module mvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mvc_pkg::dp_status_t status,
  output mvc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_CLEAR = 17'h00002,
    S_LFO   = 17'h00004,
    S_MUL   = 17'h00008,
    S_DLY   = 17'h00010,
    S_ADR   = 17'h00020,
    S_RD1   = 17'h00040,
    S_INT   = 17'h00080,
    S_ECHO  = 17'h00100,
    S_FB    = 17'h00200,
    S_WR    = 17'h00400,
    S_DIVA  = 17'h00800,
    S_WAITA = 17'h01000,
    S_DIVB  = 17'h02000,
    S_WAITB = 17'h04000,
    S_MIX   = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_LFO;
        end
      end
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_LFO: begin
        cmd.lfo = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        state_next = S_DLY;
      end
      S_DLY: begin
        cmd.dly = 1'b1;
        state_next = S_ADR;
      end
      S_ADR: begin
        cmd.adr = 1'b1;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd1 = 1'b1;
        state_next = S_INT;
      end
      S_INT: begin
        cmd.intp = 1'b1;
        state_next = S_ECHO;
      end
      S_ECHO: begin
        cmd.echo = 1'b1;
        state_next = S_FB;
      end
      S_FB: begin
        cmd.fb = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr = 1'b1;
        state_next = status.last_voice ? S_DIVA : S_LFO;
      end
      S_DIVA: begin
        cmd.div_a = 1'b1;
        state_next = S_WAITA;
      end
      S_WAITA: begin
        if (status.div_done) begin
          cmd.cap_a = 1'b1;
          state_next = status.stereo ? S_DIVB : S_MIX;
        end
      end
      S_DIVB: begin
        cmd.div_b = 1'b1;
        state_next = S_WAITB;
      end
      S_WAITB: begin
        if (status.div_done) begin
          cmd.cap_b = 1'b1;
          state_next = S_MIX;
        end
      end
      S_MIX: begin
        cmd.mix = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/mvc_datapath.sv @@
// Datapath of the chorus core: configuration registers, LFO, delay address
// arithmetic, interpolation, feedback, wet sums and output mix.
// Uses mvc_pkg, mvc_ram and mvc_div.
module mvc_datapath #(
  parameter int MAX_VOICES = 8,
  parameter int DELAY_DEPTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mvc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mvc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 req_type,
  input  logic signed [15:0]                   left_sample,
  input  logic signed [15:0]                   right_sample,
  output logic signed [15:0]                   left_out,
  output logic signed [15:0]                   right_out,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  input  mvc_pkg::dp_cmd_t                     cmd,
  output mvc_pkg::dp_status_t                  status
);

  localparam int AW = $clog2(MAX_VOICES * DELAY_DEPTH);
  localparam int WW = $clog2(DELAY_DEPTH);
  localparam int NW = $clog2(MAX_VOICES + 1);
  localparam int DLW = 27;
  localparam int DMAX = (DELAY_DEPTH - 1) * 256;

  // Configuration registers.
  logic [3:0]  voice_count;
  logic        lfo_shape;
  logic [18:0] base_delay_q8;
  logic [18:0] depth_q8;
  logic [23:0] lfo_phase_step;
  logic [14:0] feedback_gain;
  logic [15:0] wet_mix;
  logic [15:0] stereo_spread;

  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count <= 4'd2;
      lfo_shape <= 1'b0;
      base_delay_q8 <= 19'd225792;
      depth_q8 <= 19'd22528;
      lfo_phase_step <= 24'd190;
      feedback_gain <= 15'd0;
      wet_mix <= 16'd16384;
      stereo_spread <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        mvc_pkg::REG_VOICE_COUNT:    voice_count <= cfg_data[3:0];
        mvc_pkg::REG_LFO_SHAPE:      lfo_shape <= cfg_data[0];
        mvc_pkg::REG_BASE_DELAY:     base_delay_q8 <= cfg_data[18:0];
        mvc_pkg::REG_DEPTH:          depth_q8 <= cfg_data[18:0];
        mvc_pkg::REG_LFO_PHASE_STEP: lfo_phase_step <= cfg_data[23:0];
        mvc_pkg::REG_FEEDBACK_GAIN:  feedback_gain <= cfg_data[14:0];
        mvc_pkg::REG_WET_MIX:        wet_mix <= cfg_data[15:0];
        mvc_pkg::REG_STEREO_SPREAD:  stereo_spread <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] n_eff;
  logic [14:0]   fb_eff;
  logic [16:0]   mix_eff;
  logic [16:0]   spread_eff;

  always_comb begin
    if (voice_count == 4'd0) begin
      n_eff = NW'(1);
    end else if ({1'b0, voice_count} > 5'(MAX_VOICES)) begin
      n_eff = NW'(MAX_VOICES);
    end else begin
      n_eff = NW'(voice_count);
    end
    fb_eff = (feedback_gain > mvc_pkg::FB_LIMIT) ? mvc_pkg::FB_LIMIT : feedback_gain;
    mix_eff = ({1'b0, wet_mix} > mvc_pkg::Q15_ONE) ? mvc_pkg::Q15_ONE : {1'b0, wet_mix};
    spread_eff = ({1'b0, stereo_spread} > mvc_pkg::Q15_ONE) ?
                 mvc_pkg::Q15_ONE : {1'b0, stereo_spread};
  end

  // Frame state.
  logic [WW-1:0]        w_idx;
  logic [23:0]          lfo_phase;
  logic [AW-1:0]        clr_cnt;

  // Per-frame working registers.
  logic                 stereo;
  logic signed [15:0]   left_r;
  logic signed [15:0]   right_r;
  logic signed [15:0]   x_in;
  logic [NW-1:0]        voice;
  logic [23:0]          off;
  logic [4:0]           off_rem;
  logic signed [19:0]   sum_m;
  logic signed [37:0]   sum_l;
  logic signed [37:0]   sum_r;

  // Per-voice working registers.
  logic signed [16:0]   lfo_val;
  logic signed [36:0]   dprod;
  logic [WW-1:0]        d_int;
  logic [7:0]           d_frac;
  logic [WW-1:0]        r1;
  logic signed [15:0]   s0;
  logic signed [25:0]   iprod;
  logic signed [15:0]   echo;
  logic signed [30:0]   fbp;
  logic signed [34:0]   wlp;
  logic signed [34:0]   wrp;

  logic signed [mvc_pkg::WET_W-1:0] wet_l;
  logic signed [mvc_pkg::WET_W-1:0] wet_r;
  logic signed [34:0]   pdl;
  logic signed [34:0]   pwl;
  logic signed [34:0]   pdr;
  logic signed [34:0]   pwr;
  logic                 out_valid_r;

  // LFO.
  logic [23:0]                   p;
  logic [24+mvc_pkg::SIDX_W-1:0] sprod;
  logic [mvc_pkg::SIDX_W-1:0]    si;
  logic [1:0]                    quad;
  logic [mvc_pkg::SKW-1:0]       sk;
  logic [mvc_pkg::SKW-1:0]       sk_mirror;
  logic signed [18:0]            tri_t;
  logic signed [16:0]            lfo_next;

  always_comb begin
    p = lfo_phase + off;
    sprod = (24 + mvc_pkg::SIDX_W)'(p) * (24 + mvc_pkg::SIDX_W)'(4 * mvc_pkg::SINE_TABLE_SIZE);
    si = sprod[24+mvc_pkg::SIDX_W-1:24];
    quad = 2'(si / mvc_pkg::SINE_TABLE_SIZE);
    sk = mvc_pkg::SKW'(si % mvc_pkg::SINE_TABLE_SIZE);
    sk_mirror = mvc_pkg::SKW'(mvc_pkg::SINE_TABLE_SIZE) - sk;
    tri_t = $signed({2'b00, p[23:7]});
    if (lfo_shape) begin
      if (tri_t < 19'sd32768) begin
        lfo_next = 17'(tri_t);
      end else if (tri_t < 19'sd98304) begin
        lfo_next = 17'(19'sd65536 - tri_t);
      end else begin
        lfo_next = 17'(tri_t - 19'sd131072);
      end
    end else begin
      unique case (quad)
        2'd0: lfo_next = $signed({1'b0, mvc_pkg::SINE_TAB[sk]});
        2'd1: lfo_next = $signed({1'b0, mvc_pkg::SINE_TAB[sk_mirror]});
        2'd2: lfo_next = -$signed({1'b0, mvc_pkg::SINE_TAB[sk]});
        2'd3: lfo_next = -$signed({1'b0, mvc_pkg::SINE_TAB[sk_mirror]});
      endcase
    end
  end

  // Delay clamp and read addresses.
  logic signed [DLW-1:0] d_raw;
  logic signed [DLW-1:0] d_cl;
  logic [WW:0]           r0_diff;
  logic [WW-1:0]         r0;
  logic [WW-1:0]         r1_next;
  logic [AW-1:0]         voice_base;

  always_comb begin
    d_raw = $signed({8'd0, base_delay_q8}) + DLW'(dprod >>> 15);
    if (d_raw < $signed(DLW'(256))) begin
      d_cl = $signed(DLW'(256));
    end else if (d_raw > $signed(DLW'(DMAX))) begin
      d_cl = $signed(DLW'(DMAX));
    end else begin
      d_cl = d_raw;
    end
    r0_diff = {1'b0, w_idx} - {1'b0, d_int};
    if (r0_diff[WW]) begin
      r0 = WW'({1'b0, w_idx} + (WW+1)'(DELAY_DEPTH) - {1'b0, d_int});
    end else begin
      r0 = r0_diff[WW-1:0];
    end
    r1_next = (r0 == '0) ? WW'(DELAY_DEPTH - 1) : r0 - 1'b1;
    voice_base = AW'(voice) * AW'(DELAY_DEPTH);
  end

  // Delay line memory.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [15:0]         ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [15:0]         ram_rdata;
  logic signed [15:0]  wval;

  assign wval = mvc_pkg::sat16(40'(x_in) + 40'(fbp >>> 15));
  assign ram_we = cmd.clear_wr | cmd.wr;
  assign ram_waddr = cmd.clear_wr ? clr_cnt : voice_base + AW'(w_idx);
  assign ram_wdata = cmd.clear_wr ? 16'd0 : wval;
  assign ram_re = cmd.adr | cmd.rd1;
  assign ram_raddr = voice_base + AW'(cmd.adr ? r0 : r1);

  mvc_ram #(
    .WIDTH(16),
    .DEPTH(MAX_VOICES * DELAY_DEPTH)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Wet division by the voice count.
  logic signed [mvc_pkg::DIV_W-1:0] div_in;
  logic signed [mvc_pkg::DIV_W-1:0] div_q;
  logic                             div_done;

  always_comb begin
    if (cmd.div_b) begin
      div_in = mvc_pkg::DIV_W'(sum_r >>> 15);
    end else if (stereo) begin
      div_in = mvc_pkg::DIV_W'(sum_l >>> 15);
    end else begin
      div_in = mvc_pkg::DIV_W'(sum_m);
    end
  end

  mvc_div #(
    .DW(mvc_pkg::DIV_W),
    .NW(NW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(cmd.div_a | cmd.div_b),
    .dividend(div_in),
    .divisor(n_eff),
    .quotient(div_q),
    .done(div_done)
  );

  logic [5:0]         rem_sum;
  logic               off_carry;
  logic signed [17:0] gain_l;
  logic signed [17:0] gain_r;
  logic signed [17:0] gain_hi;
  logic signed [17:0] gain_lo;

  always_comb begin
    rem_sum = {1'b0, off_rem} + {1'b0, mvc_pkg::OFF_R[5'(n_eff)]};
    off_carry = rem_sum >= 6'(n_eff);
    gain_hi = $signed({1'b0, 17'(mvc_pkg::Q15_ONE) + spread_eff});
    gain_lo = $signed({1'b0, 17'(mvc_pkg::Q15_ONE) - spread_eff});
    gain_l = voice[0] ? gain_lo : gain_hi;
    gain_r = voice[0] ? gain_hi : gain_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_idx <= '0;
      lfo_phase <= '0;
      clr_cnt <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear_wr) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        w_idx <= (w_idx == WW'(DELAY_DEPTH - 1)) ? '0 : w_idx + 1'b1;
        lfo_phase <= lfo_phase + lfo_phase_step;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stereo <= req_type;
      left_r <= left_sample;
      right_r <= right_sample;
      x_in <= req_type ? 16'((17'(left_sample) + 17'(right_sample)) >>> 1) : left_sample;
      voice <= '0;
      off <= '0;
      off_rem <= '0;
      sum_m <= '0;
      sum_l <= '0;
      sum_r <= '0;
    end
    if (cmd.lfo) begin
      lfo_val <= lfo_next;
    end
    if (cmd.mul) begin
      dprod <= lfo_val * $signed({1'b0, depth_q8});
    end
    if (cmd.dly) begin
      d_int <= d_cl[WW+7:8];
      d_frac <= d_cl[7:0];
    end
    if (cmd.adr) begin
      r1 <= r1_next;
    end
    if (cmd.rd1) begin
      s0 <= $signed(ram_rdata);
    end
    if (cmd.intp) begin
      iprod <= $signed({1'b0, d_frac}) * (17'($signed(ram_rdata)) - 17'(s0));
    end
    if (cmd.echo) begin
      echo <= 16'(26'(s0) + (iprod >>> 8));
    end
    if (cmd.fb) begin
      fbp <= echo * $signed({1'b0, fb_eff});
      wlp <= echo * gain_l;
      wrp <= echo * gain_r;
    end
    if (cmd.wr) begin
      sum_m <= sum_m + 20'(echo);
      sum_l <= sum_l + 38'(wlp);
      sum_r <= sum_r + 38'(wrp);
      voice <= voice + 1'b1;
      off <= off + mvc_pkg::OFF_Q[5'(n_eff)] + 24'(off_carry);
      off_rem <= off_carry ? 5'(rem_sum - 6'(n_eff)) : 5'(rem_sum);
    end
    if (cmd.cap_a) begin
      wet_l <= mvc_pkg::WET_W'(div_q);
    end
    if (cmd.cap_b) begin
      wet_r <= mvc_pkg::WET_W'(div_q);
    end
    if (cmd.mix) begin
      pdl <= left_r * $signed({1'b0, 17'(mvc_pkg::Q15_ONE) - mix_eff});
      pwl <= wet_l * $signed({1'b0, mix_eff});
      pdr <= right_r * $signed({1'b0, 17'(mvc_pkg::Q15_ONE) - mix_eff});
      pwr <= wet_r * $signed({1'b0, mix_eff});
    end
    if (cmd.out_load) begin
      left_out <= mvc_pkg::sat16(40'((36'(pdl) + 36'(pwl)) >>> 15));
      right_out <= stereo ? mvc_pkg::sat16(40'((36'(pdr) + 36'(pwr)) >>> 15)) :
                            mvc_pkg::sat16(40'((36'(pdl) + 36'(pwl)) >>> 15));
    end
  end

  assign out_valid = out_valid_r;
  assign status.clear_last = (clr_cnt == AW'(MAX_VOICES * DELAY_DEPTH - 1));
  assign status.last_voice = (voice == n_eff - 1'b1);
  assign status.stereo = stereo;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || !out_stall;

endmodule
